// ===== rtl/jsau_pkg.sv =====
// Shared types and constants for the JSON string array unescaper.
package jsau_pkg;

	// Scanner phases
	typedef enum logic [2:0] {
		PH_OUT,
		PH_IN,
		PH_ESC,
		PH_HEX,
		PH_WANT_BS,
		PH_WANT_U,
		PH_LOW_HEX
	} phase_t;

	// Kind of one queued result word
	typedef enum logic [1:0] {
		K_BYTE,
		K_SEND,
		K_DONE,
		K_ERR
	} kind_t;

	// Result slots per input byte: replacement prefix (3), 'u' (1),
	// held digits (3), main group (4), trailing error (1)
	localparam int NSLOT   = 12;
	localparam int MAX_RES = 10;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       msg_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       string_end;
		logic       array_done;
		logic       parse_error;
		logic       run_last;
	} out_item_t;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
	} slot_t;

	// Scanner state, bracket depth kept apart since its width is parameterized
	typedef struct packed {
		phase_t      phase;
		logic        collecting;
		logic [15:0] code_unit_acc;
		logic [9:0]  high_unit_held;
		logic [1:0]  digit_count;
		logic        finished;
	} scan_st_t;

	// Write strobe for the held hex digit registers
	typedef struct packed {
		logic       we;
		logic [1:0] idx;
	} held_wr_t;

	localparam scan_st_t SCAN_RST = '{
		phase:          PH_OUT,
		collecting:     1'b0,
		code_unit_acc:  16'h0000,
		high_unit_held: 10'h000,
		digit_count:    2'd0,
		finished:       1'b0
	};

endpackage

// ===== rtl/jsau_step.sv =====
// Next-state and result-slot logic for one input byte of the unescaper.
module jsau_step #(
	parameter int DEPTH_LIMIT = 255
) (
	input  jsau_pkg::in_item_t                      item,
	input  jsau_pkg::scan_st_t                      st,
	input  logic [$clog2(DEPTH_LIMIT+1)-1:0]        depth,
	input  logic [2:0][7:0]                         held,
	output jsau_pkg::scan_st_t                      st_nxt,
	output logic [$clog2(DEPTH_LIMIT+1)-1:0]        depth_nxt,
	output jsau_pkg::held_wr_t                      held_wr,
	output jsau_pkg::slot_t [jsau_pkg::NSLOT-1:0]   slots,
	output logic [jsau_pkg::NSLOT-1:0]              slot_en
);

	localparam int DW = $clog2(DEPTH_LIMIT+1);

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRK   = 8'h5B;
	localparam logic [7:0] CH_RBRK   = 8'h5D;
	localparam logic [7:0] CH_LC_U   = 8'h75;
	localparam logic [7:0] CH_LC_B   = 8'h62;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_LC_N   = 8'h6E;
	localparam logic [7:0] CH_LC_R   = 8'h72;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;

	localparam logic [20:0] CP_REPL     = 21'h00FFFD;
	localparam logic [20:0] CP_SUPP_OFS = 21'h010000;
	localparam logic [15:0] HI_FIRST    = 16'hD800;
	localparam logic [15:0] HI_LAST     = 16'hDBFF;
	localparam logic [15:0] LO_FIRST    = 16'hDC00;
	localparam logic [15:0] LO_LAST     = 16'hDFFF;

	typedef enum logic [2:0] {
		M_NONE,
		M_BYTE,
		M_UTF8,
		M_SEND,
		M_DONE,
		M_ERR
	} main_t;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      len;
	} utf8_t;

	// UTF-8 encoding of one code point, up to four bytes
	function automatic utf8_t utf8_enc(input logic [20:0] cp);
		utf8_t r;
		r = '0;
		if (cp <= 21'h00007F) begin
			r.b[0] = cp[7:0];
			r.len  = 3'd1;
		end else if (cp <= 21'h0007FF) begin
			r.b[0] = {3'b110, cp[10:6]};
			r.b[1] = {2'b10, cp[5:0]};
			r.len  = 3'd2;
		end else if (cp <= 21'h00FFFF) begin
			r.b[0] = {4'b1110, cp[15:12]};
			r.b[1] = {2'b10, cp[11:6]};
			r.b[2] = {2'b10, cp[5:0]};
			r.len  = 3'd3;
		end else begin
			r.b[0] = {5'b11110, cp[20:18]};
			r.b[1] = {2'b10, cp[17:12]};
			r.b[2] = {2'b10, cp[11:6]};
			r.b[3] = {2'b10, cp[5:0]};
			r.len  = 3'd4;
		end
		return r;
	endfunction

	logic [7:0]  c;
	logic        hv_ok;
	logic [3:0]  hv;
	logic [15:0] acc_nxt;
	logic        acc_is_lo;
	logic        acc_is_hi;
	logic [20:0] pair_cp;
	logic        pre_repl;
	logic        u_en;
	logic [1:0]  dig_n;
	main_t       mk;
	logic [7:0]  mb;
	logic [20:0] mcp;
	logic        err_tail;
	logic        do_instr;
	logic        do_esc;
	logic        do_fin;
	utf8_t       repl_enc;
	utf8_t       main_enc;

	assign c = item.in_byte;

	// Hex digit decode
	always_comb begin
		hv_ok = 1'b0;
		hv    = c[3:0];
		if (c >= 8'h30 && c <= 8'h39) begin
			hv_ok = 1'b1;
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			hv_ok = 1'b1;
			hv    = c[3:0] + 4'd9;
		end
	end

	assign acc_nxt   = {st.code_unit_acc[11:0], hv};
	assign acc_is_lo = (acc_nxt >= LO_FIRST) && (acc_nxt <= LO_LAST);
	assign acc_is_hi = (acc_nxt >= HI_FIRST) && (acc_nxt <= HI_LAST);
	assign pair_cp   = {1'b0, st.high_unit_held, acc_nxt[9:0]} + CP_SUPP_OFS;

	// Scanner: phase dispatch, then shared string / escape / unit-finish handling
	always_comb begin
		st_nxt     = st;
		depth_nxt  = depth;
		held_wr    = '0;
		pre_repl   = 1'b0;
		u_en       = 1'b0;
		dig_n      = 2'd0;
		mk         = M_NONE;
		mb         = c;
		mcp        = CP_REPL;
		err_tail   = 1'b0;
		do_instr   = 1'b0;
		do_esc     = 1'b0;
		do_fin     = 1'b0;

		if (!st.finished) begin
			case (st.phase)
				jsau_pkg::PH_OUT: begin
					if (c == CH_QUOTE) begin
						st_nxt.phase      = jsau_pkg::PH_IN;
						st_nxt.collecting = (depth == DW'(1));
					end else if (c == CH_LBRK) begin
						if (depth >= DW'(DEPTH_LIMIT)) begin
							mk              = M_ERR;
							st_nxt.finished = 1'b1;
						end else begin
							depth_nxt = depth + DW'(1);
						end
					end else if (c == CH_RBRK) begin
						if (depth <= DW'(1)) begin
							depth_nxt       = '0;
							mk              = M_DONE;
							st_nxt.finished = 1'b1;
						end else begin
							depth_nxt = depth - DW'(1);
						end
					end
				end
				jsau_pkg::PH_IN: begin
					do_instr = 1'b1;
				end
				jsau_pkg::PH_ESC: begin
					do_esc = 1'b1;
				end
				jsau_pkg::PH_HEX: begin
					if (!hv_ok) begin
						u_en     = 1'b1;
						dig_n    = st.digit_count;
						do_instr = 1'b1;
					end else if (st.digit_count != 2'd3) begin
						held_wr.we           = 1'b1;
						held_wr.idx          = st.digit_count;
						st_nxt.code_unit_acc = acc_nxt;
						st_nxt.digit_count   = st.digit_count + 2'd1;
					end else begin
						do_fin = 1'b1;
					end
				end
				jsau_pkg::PH_WANT_BS: begin
					if (c == CH_BSLASH) begin
						st_nxt.phase = jsau_pkg::PH_WANT_U;
					end else begin
						pre_repl = 1'b1;
						do_instr = 1'b1;
					end
				end
				jsau_pkg::PH_WANT_U: begin
					if (c == CH_LC_U) begin
						st_nxt.phase         = jsau_pkg::PH_LOW_HEX;
						st_nxt.digit_count   = 2'd0;
						st_nxt.code_unit_acc = '0;
					end else begin
						pre_repl = 1'b1;
						do_esc   = 1'b1;
					end
				end
				jsau_pkg::PH_LOW_HEX: begin
					if (!hv_ok) begin
						pre_repl = 1'b1;
						u_en     = 1'b1;
						dig_n    = st.digit_count;
						do_instr = 1'b1;
					end else if (st.digit_count != 2'd3) begin
						held_wr.we           = 1'b1;
						held_wr.idx          = st.digit_count;
						st_nxt.code_unit_acc = acc_nxt;
						st_nxt.digit_count   = st.digit_count + 2'd1;
					end else if (acc_is_lo) begin
						mk           = M_UTF8;
						mcp          = pair_cp;
						st_nxt.phase = jsau_pkg::PH_IN;
					end else begin
						pre_repl = 1'b1;
						do_fin   = 1'b1;
					end
				end
				default: begin
					st_nxt.phase = jsau_pkg::PH_OUT;
				end
			endcase
		end

		// Plain byte inside a string
		if (do_instr) begin
			if (c == CH_BSLASH) begin
				st_nxt.phase = jsau_pkg::PH_ESC;
			end else if (c == CH_QUOTE) begin
				if (st.collecting) begin
					mk = M_SEND;
				end
				st_nxt.phase      = jsau_pkg::PH_OUT;
				st_nxt.collecting = 1'b0;
			end else begin
				st_nxt.phase = jsau_pkg::PH_IN;
				if (st.collecting) begin
					mk = M_BYTE;
				end
			end
		end

		// Byte after a backslash
		if (do_esc) begin
			st_nxt.phase = jsau_pkg::PH_IN;
			if (st.collecting) begin
				mk = M_BYTE;
				case (c)
					CH_LC_B: mb = CH_BS;
					CH_LC_F: mb = CH_FF;
					CH_LC_N: mb = CH_LF;
					CH_LC_R: mb = CH_CR;
					CH_LC_T: mb = CH_TAB;
					CH_LC_U: begin
						mk                   = M_NONE;
						st_nxt.phase         = jsau_pkg::PH_HEX;
						st_nxt.digit_count   = 2'd0;
						st_nxt.code_unit_acc = '0;
					end
					default: mb = c;
				endcase
			end
		end

		// Complete code unit: hold a high surrogate, otherwise encode
		if (do_fin) begin
			if (acc_is_hi) begin
				st_nxt.high_unit_held = acc_nxt[9:0];
				st_nxt.phase          = jsau_pkg::PH_WANT_BS;
			end else begin
				mk           = M_UTF8;
				mcp          = acc_is_lo ? CP_REPL : {5'b0, acc_nxt};
				st_nxt.phase = jsau_pkg::PH_IN;
			end
		end

		// End of message: flag an array still open after this byte, then reset state
		if (item.msg_last) begin
			err_tail  = !st_nxt.finished;
			st_nxt    = jsau_pkg::SCAN_RST;
			depth_nxt = DW'(1);
		end
	end

	assign repl_enc = utf8_enc(CP_REPL);
	assign main_enc = utf8_enc(mcp);

	// Fixed slot layout; enables pick the words that are really produced
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			slots[i]   = '{data: repl_enc.b[i], kind: jsau_pkg::K_BYTE};
			slot_en[i] = pre_repl;
		end
		slots[3]   = '{data: CH_LC_U, kind: jsau_pkg::K_BYTE};
		slot_en[3] = u_en;
		for (int i = 0; i < 3; i++) begin
			slots[4+i]   = '{data: held[i], kind: jsau_pkg::K_BYTE};
			slot_en[4+i] = u_en && (2'(i) < dig_n);
		end
		for (int i = 0; i < 4; i++) begin
			slots[7+i]   = '{data: main_enc.b[i], kind: jsau_pkg::K_BYTE};
			slot_en[7+i] = (mk == M_UTF8) && (3'(i) < main_enc.len);
		end
		case (mk)
			M_BYTE: begin
				slots[7]   = '{data: mb, kind: jsau_pkg::K_BYTE};
				slot_en[7] = 1'b1;
			end
			M_SEND: begin
				slots[7]   = '{data: 8'h00, kind: jsau_pkg::K_SEND};
				slot_en[7] = 1'b1;
			end
			M_DONE: begin
				slots[7]   = '{data: 8'h00, kind: jsau_pkg::K_DONE};
				slot_en[7] = 1'b1;
			end
			M_ERR: begin
				slots[7]   = '{data: 8'h00, kind: jsau_pkg::K_ERR};
				slot_en[7] = 1'b1;
			end
			default: begin
			end
		endcase
		slots[11]   = '{data: 8'h00, kind: jsau_pkg::K_ERR};
		slot_en[11] = err_tail;
	end

endmodule

// ===== rtl/json_string_array_unescaper.sv =====
// A byte is first taken into the input register; its result words are loaded into the
// result register once that register is free, and the first word is then offered.
// Throughput: one byte per cycle while tx_ready is high and each byte yields at most
// one word; a byte that yields more words (at most 10) holds the input until the single
// result port drains the result register, one word per cycle while tx_ready is high.
// Reset (arst_n low, asynchronous): outside any string, bracket depth one, result
// register empty; no clearing pass.
module json_string_array_unescaper #(
	parameter int DEPTH_LIMIT = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rx_valid,
	output logic                rx_ready,
	input  jsau_pkg::in_item_t  rx_word,
	output logic                tx_valid,
	input  logic                tx_ready,
	output jsau_pkg::out_item_t tx_word
);

	localparam int DW = $clog2(DEPTH_LIMIT+1);
	localparam int SW = $clog2(jsau_pkg::NSLOT);

	logic                                  valid_s1;
	jsau_pkg::in_item_t                    item_s1;
	jsau_pkg::scan_st_t                    st_q;
	logic [DW-1:0]                         depth_q;
	logic [2:0][7:0]                       held_q;
	jsau_pkg::slot_t [jsau_pkg::NSLOT-1:0] slots_q;
	logic [jsau_pkg::NSLOT-1:0]            mask_q;

	jsau_pkg::scan_st_t                    st_nxt;
	logic [DW-1:0]                         depth_nxt;
	jsau_pkg::held_wr_t                    held_wr;
	jsau_pkg::slot_t [jsau_pkg::NSLOT-1:0] slots;
	logic [jsau_pkg::NSLOT-1:0]            slot_en;

	logic [jsau_pkg::NSLOT-1:0] mask_rest;
	logic [SW-1:0]              sel;
	jsau_pkg::slot_t            cur;
	logic                       tx_fire;
	logic                       burst_free;
	logic                       adv_s1;

	jsau_step #(
		.DEPTH_LIMIT(DEPTH_LIMIT)
	) u_step (
		.item      (item_s1),
		.st        (st_q),
		.depth     (depth_q),
		.held      (held_q),
		.st_nxt    (st_nxt),
		.depth_nxt (depth_nxt),
		.held_wr   (held_wr),
		.slots     (slots),
		.slot_en   (slot_en)
	);

	// Handshake: result register frees when its last pending word leaves
	assign mask_rest  = mask_q & (mask_q - jsau_pkg::NSLOT'(1));
	assign tx_valid   = |mask_q;
	assign tx_fire    = tx_valid && tx_ready;
	assign burst_free = (mask_q == '0) || (tx_fire && (mask_rest == '0));
	assign adv_s1     = valid_s1 && burst_free;
	assign rx_ready   = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			item_s1 <= rx_word;
		end
	end

	// Scanner state and result mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= jsau_pkg::SCAN_RST;
			depth_q <= DW'(1);
			mask_q  <= '0;
		end else if (adv_s1) begin
			st_q    <= st_nxt;
			depth_q <= depth_nxt;
			mask_q  <= slot_en;
		end else if (tx_fire) begin
			mask_q  <= mask_rest;
		end
	end

	// Payload registers: held hex digits and result words
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			slots_q <= slots;
			if (held_wr.we) begin
				held_q[held_wr.idx] <= item_s1.in_byte;
			end
		end
	end

	// Lowest pending slot drives the output word
	always_comb begin
		sel = '0;
		for (int i = jsau_pkg::NSLOT - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel = SW'(i);
			end
		end
	end

	assign cur                 = slots_q[sel];
	assign tx_word.out_byte    = (cur.kind == jsau_pkg::K_BYTE) ? cur.data : 8'h00;
	assign tx_word.byte_valid  = (cur.kind == jsau_pkg::K_BYTE);
	assign tx_word.string_end  = (cur.kind == jsau_pkg::K_SEND);
	assign tx_word.array_done  = (cur.kind == jsau_pkg::K_DONE);
	assign tx_word.parse_error = (cur.kind == jsau_pkg::K_ERR);
	assign tx_word.run_last    = (mask_rest == '0);

`ifndef SYNTHESIS
	// A message end always returns the scanner to its reset state
	a_msg_end_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && item_s1.msg_last) |=>
		(st_q.phase == jsau_pkg::PH_OUT && depth_q == DW'(1) && !st_q.finished))
		else $error("scanner not reset after message end");

	// No byte yields more words than the result bound
	a_burst_bound: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |-> ($countones(slot_en) <= jsau_pkg::MAX_RES))
		else $error("too many result words for one byte");

	// Done or error is only reached from outside a string
	a_finished_out: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.finished |-> (st_q.phase == jsau_pkg::PH_OUT))
		else $error("finished while inside a string");

	// A waiting byte is never held while the result register is empty
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && mask_q == '0) |=> !$past(valid_s1) || $past(adv_s1))
		else $error("input held with empty result register");
`endif

endmodule
